@@ rtl/gpi_pkg.sv @@
`default_nettype none
package gpi_pkg;
  localparam int unsigned MaxRows = 16;
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned RowW = $clog2(MaxRows);
  localparam int unsigned PtW = $clog2(MaxPoints);
  localparam int unsigned CntW = PtW + 1;
  localparam int unsigned AddrW = RowW + PtW;

  localparam logic [2:0] StInterp = 3'd0;
  localparam logic [2:0] StHeld = 3'd1;
  localparam logic [2:0] StEmpty = 3'd2;
  localparam logic [2:0] StEqual = 3'd3;
  localparam logic [2:0] StOverflow = 3'd4;

  localparam logic CfgGamma = 1'b0;
  localparam logic CfgRowCount = 1'b1;

  typedef struct packed {
    logic [31:0] beta;
    logic [RowW-1:0] row;
    logic [2:0] status;
    logic last;
  } result_t;
endpackage
`default_nettype wire

@@ rtl/gpi_divider.sv @@
`default_nettype none
// Restoring divider: one quotient bit per cycle; 64-bit numerator, 33-bit denominator.
module gpi_divider
  import gpi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             done_o,
  output logic [63:0]      quot_o
);
  logic [63:0] quot_q, quot_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [33:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      quot_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[32:0], quot_q[63]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d = trial;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule
`default_nettype wire

@@ rtl/gpi_point_mem.sv @@
`default_nettype none
// Point store: alpha and lambda side by side, one write and one registered read port.
module gpi_point_mem
  import gpi_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [63:0]      wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic [63:0]           rdata_o
);
  logic [63:0] mem [2**AddrW];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

@@ rtl/grouped_path_interpolator_unit.sv @@
`default_nettype none
// Timing: a point is stored in the cycle after it is accepted, unless it opens a new column,
// in which case the previous column is closed first; a column close reads each row's points
// from the point memory (a read, then a compare, per point; one scan of n points per sorted
// position up to the chosen pair) and, for an interpolated row, then runs the divider.
// Flow: a point is accepted, then stored, and no new point is accepted before it is stored;
// input stalls during a close.
// Reset: asynchronous, active low; clears counts, flags, column state and registers.
module grouped_path_interpolator_unit
  import gpi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [103:0] s_axis_tdata,  // alpha_value, lambda_value, row_number, column_id
  input  wire logic        s_axis_tlast,   // final_item
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // beta_value, row_index, status
  output logic             m_axis_tlast,   // last_of_run
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SRowStart = 4'd1;
  localparam logic [3:0] SMinRd = 4'd2;   // unused; the scan for the next minimum key runs through SMinWait and SMinCmp
  localparam logic [3:0] SMinWait = 4'd3;
  localparam logic [3:0] SMinCmp = 4'd4;
  localparam logic [3:0] SMinDone = 4'd5;
  localparam logic [3:0] SMul = 4'd6;
  localparam logic [3:0] SDiv = 4'd7;
  localparam logic [3:0] SEmit = 4'd8;
  localparam logic [3:0] SStore = 4'd9;

  logic [31:0] gamma_q;
  logic [4:0] rowcnt_q;
  logic [CntW-1:0] cnt_q [MaxRows];
  logic [MaxRows-1:0] ovf_q;
  logic [31:0] prevcol_q;
  logic open_q;
  logic [3:0] st_q;

  logic [31:0] in_alpha, in_lam, in_col;
  logic [4:0] in_row;
  assign in_alpha = s_axis_tdata[31:0];
  assign in_lam = s_axis_tdata[63:32];
  assign in_row = s_axis_tdata[68:64];
  assign in_col = s_axis_tdata[100:69];

  logic [4:0] k_eff;
  always_comb begin
    k_eff = rowcnt_q;
    if (k_eff == 5'd0) k_eff = 5'd1;
    if (k_eff > 5'(MaxRows)) k_eff = 5'(MaxRows);
  end

  // pending request held while closing
  logic [100:0] hold_data_q;
  logic hold_fin_q, pend_store_q, pend_close_q;

  logic [RowW-1:0] row_q;
  logic [CntW-1:0] n_q, i_q;
  // sorted selection: elements are ordered by (lambda, index); we find ranks 0.. via scans
  logic [PtW-1:0] rank_q;          // how many sorted positions passed so far
  logic [31:0] cur_lam_q;          // key of last picked element
  logic [PtW-1:0] cur_idx_q;
  logic [31:0] cur_alpha_q;
  logic [31:0] prv_lam_q, prv_alpha_q;
  logic have_q;                    // a first element has been picked
  logic [31:0] best_lam_q, best_alpha_q;
  logic [PtW-1:0] best_idx_q;
  logic best_ok_q;
  logic [63:0] prod_q;
  logic neg_q;
  logic [32:0] den_q;
  logic [31:0] beta_q;
  logic [2:0] stat_q;
  result_t out_q;
  logic out_v_q;

  logic mem_we;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic [63:0] mem_rd;

  // store happens from the held request
  logic [31:0] h_alpha, h_lam;
  logic [4:0] h_row;
  logic [RowW-1:0] h_r;
  logic h_ok;
  assign h_alpha = hold_data_q[31:0];
  assign h_lam = hold_data_q[63:32];
  assign h_row = hold_data_q[68:64];
  assign h_r = RowW'(h_row - 5'd1);
  assign h_ok = (h_row >= 5'd1) && (h_row <= k_eff);

  gpi_point_mem u_mem (
    .clk_i(clk_i), .we_i(mem_we), .waddr_i(mem_wa),
    .wdata_i({h_lam, h_alpha}), .raddr_i(mem_ra), .rdata_o(mem_rd)
  );

  logic div_start, div_done;
  logic [63:0] div_q;
  gpi_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(prod_q + {32'd0, den_q[32:1]}), .den_i(den_q),
    .done_o(div_done), .quot_o(div_q)
  );

  logic acc;
  logic need_close;
  assign s_axis_tready = (st_q == SIdle) && !pend_store_q && !pend_close_q;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign need_close = open_q && (in_col != prevcol_q);

  assign mem_we = 1'b0 || (st_q == SStore && h_ok && cnt_q[h_r] < CntW'(MaxPoints));
  assign mem_wa = {h_r, cnt_q[h_r][PtW-1:0]};
  assign mem_ra = {row_q, i_q[PtW-1:0]};

  // candidate comparison: strictly after current key in (lambda, idx) order, better than best
  logic [31:0] m_alpha, m_lam;
  logic after_cur, better;
  assign m_alpha = mem_rd[31:0];
  assign m_lam = mem_rd[63:32];
  always_comb begin
    after_cur = !have_q || (m_lam > cur_lam_q) ||
                (m_lam == cur_lam_q && i_q[PtW-1:0] > cur_idx_q);
    better = !best_ok_q || (m_lam < best_lam_q);
  end

  logic [32:0] dy, dx;
  logic [31:0] mdy, mdx;
  assign dy = {cur_alpha_q[31], cur_alpha_q} - {prv_alpha_q[31], prv_alpha_q};
  assign dx = {1'b0, gamma_q} - {1'b0, prv_lam_q};

  logic [34:0] sum;
  logic [34:0] qs;
  always_comb begin
    qs = (div_q > 64'h2_0000_0000) ? 35'h2_0000_0000 : div_q[34:0];
    sum = {{3{cur_alpha_q[31]}}, cur_alpha_q} + (neg_q ? -qs : qs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= '0;
      rowcnt_q <= 5'd16;
      for (int r = 0; r < MaxRows; r++) cnt_q[r] <= '0;
      ovf_q <= '0;
      prevcol_q <= '0;
      open_q <= 1'b0;
      st_q <= SIdle;
      pend_store_q <= 1'b0;
      pend_close_q <= 1'b0;
      out_v_q <= 1'b0;
      hold_fin_q <= 1'b0;
      hold_data_q <= '0;
      row_q <= '0;
      n_q <= '0;
      i_q <= '0;
      rank_q <= '0;
      cur_lam_q <= '0;
      cur_idx_q <= '0;
      cur_alpha_q <= '0;
      prv_lam_q <= '0;
      prv_alpha_q <= '0;
      have_q <= 1'b0;
      best_lam_q <= '0;
      best_alpha_q <= '0;
      best_idx_q <= '0;
      best_ok_q <= 1'b0;
      prod_q <= '0;
      neg_q <= 1'b0;
      den_q <= '0;
      beta_q <= '0;
      stat_q <= StInterp;
      out_q <= '0;
      div_start <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgGamma) gamma_q <= cfg_data_i;
        else rowcnt_q <= cfg_data_i[4:0];
      end
      if (out_v_q && m_axis_tready && st_q != SEmit) out_v_q <= 1'b0;
      div_start <= 1'b0;
      case (st_q)
        SIdle: begin
          if (acc) begin
            hold_data_q <= s_axis_tdata[100:0];
            hold_fin_q <= s_axis_tlast;
            pend_store_q <= 1'b1;
            pend_close_q <= need_close;
            if (need_close) begin
              row_q <= '0;
              st_q <= SRowStart;
            end else begin
              st_q <= SStore;
            end
          end
        end
        SStore: begin
          if (h_ok) begin
            if (cnt_q[h_r] < CntW'(MaxPoints)) cnt_q[h_r] <= cnt_q[h_r] + 1'b1;
            else ovf_q[h_r] <= 1'b1;
          end
          prevcol_q <= hold_data_q[100:69];
          open_q <= !hold_fin_q;
          pend_store_q <= 1'b0;
          if (hold_fin_q) begin
            pend_close_q <= 1'b1;
            row_q <= '0;
            st_q <= SRowStart;
          end else begin
            st_q <= SIdle;
          end
        end
        SRowStart: begin
          n_q <= cnt_q[row_q];
          have_q <= 1'b0;
          rank_q <= '0;
          if (cnt_q[row_q] == '0) begin
            beta_q <= '0;
            stat_q <= StEmpty;
            st_q <= SEmit;
          end else begin
            i_q <= '0;
            best_ok_q <= 1'b0;
            st_q <= SMinWait;
          end
        end
        SMinWait: st_q <= SMinCmp;
        SMinCmp: begin
          if (after_cur && better) begin
            best_ok_q <= 1'b1;
            best_lam_q <= m_lam;
            best_alpha_q <= m_alpha;
            best_idx_q <= i_q[PtW-1:0];
          end
          if (i_q + 1'b1 == n_q) st_q <= SMinDone;
          else begin
            i_q <= i_q + 1'b1;
            st_q <= SMinWait;
          end
        end
        SMinDone: begin
          // best is the sorted element at position rank_q
          prv_lam_q <= cur_lam_q;
          prv_alpha_q <= cur_alpha_q;
          cur_lam_q <= best_lam_q;
          cur_alpha_q <= best_alpha_q;
          cur_idx_q <= best_idx_q;
          have_q <= 1'b1;
          i_q <= '0;
          best_ok_q <= 1'b0;
          if (n_q == CntW'(1)) begin
            beta_q <= best_alpha_q;
            stat_q <= StHeld;
            st_q <= SEmit;
          end else if (rank_q != '0 && !(gamma_q > best_lam_q)) begin
            if (best_lam_q == cur_lam_q) begin
              beta_q <= cur_alpha_q;
              stat_q <= StEqual;
              st_q <= SEmit;
            end else begin
              st_q <= SMul;
            end
          end else if (CntW'(rank_q) + 1'b1 == n_q) begin
            beta_q <= best_alpha_q;
            stat_q <= StHeld;
            st_q <= SEmit;
          end else begin
            rank_q <= rank_q + 1'b1;
            st_q <= SMinWait;
          end
        end
        SMul: begin
          // here prv = element rank-1, cur = element rank
          prod_q <= 64'(mdy) * 64'(mdx);
          neg_q <= dy[32] ^ dx[32];
          den_q <= {1'b0, cur_lam_q} - {1'b0, prv_lam_q};
          cur_alpha_q <= prv_alpha_q;
          div_start <= 1'b1;
          st_q <= SDiv;
        end
        SDiv: begin
          if (div_done) begin
            if ($signed(sum) > 35'sh0_7FFF_FFFF) beta_q <= 32'h7FFF_FFFF;
            else if ($signed(sum) < -35'sh0_8000_0000) beta_q <= 32'h8000_0000;
            else beta_q <= sum[31:0];
            stat_q <= StInterp;
            st_q <= SEmit;
          end
        end
        SEmit: begin
          if (!out_v_q || m_axis_tready) begin
            out_v_q <= 1'b1;
            out_q.beta <= beta_q;
            out_q.row <= row_q;
            out_q.status <= ovf_q[row_q] ? StOverflow : stat_q;
            out_q.last <= (5'(row_q) + 5'd1 == k_eff);
            if (5'(row_q) + 5'd1 == k_eff) begin
              for (int r = 0; r < MaxRows; r++) cnt_q[r] <= '0;
              ovf_q <= '0;
              pend_close_q <= 1'b0;
              st_q <= pend_store_q ? SStore : SIdle;
            end else begin
              row_q <= row_q + 1'b1;
              st_q <= SRowStart;
            end
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  // magnitudes for the product; during SMul prv/cur hold pair (y0 at rank-1, y1 at rank)
  logic [32:0] dyv, dxv;
  always_comb begin
    dyv = {cur_alpha_q[31], cur_alpha_q} - {prv_alpha_q[31], prv_alpha_q};
    dxv = {1'b0, gamma_q} - {1'b0, prv_lam_q};
    mdy = dyv[32] ? 32'(-dyv) : dyv[31:0];
    mdx = dxv[32] ? 32'(-dxv) : dxv[31:0];
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = {1'b0, out_q.status, out_q.row, out_q.beta};
  assign m_axis_tlast = out_q.last;
endmodule
`default_nettype wire
